// File: hw/rtl/xst_pkg.sv
// Package: types, constants and character-class functions for the XML tokenizer.
`default_nettype none
package xst_pkg;

    localparam int POS_WIDTH_DEF      = 32;
    localparam int DEPTH_WIDTH_DEF    = 16;
    localparam int CHAR_WIDTH_DEF     = 16;
    localparam int MAX_DT_FIELDS_DEF  = 4;
    localparam int MAX_EVENTS         = 3;
    localparam int QUEUE_DEPTH        = 4;

    typedef enum logic [4:0] {
        PH_READY, PH_TAG_BEGIN, PH_TAG_NAME, PH_TAG_INSIDE, PH_ATTR_NAME, PH_ATTR_EQ,
        PH_ATTR_QUOTE, PH_ATTR_VALUE, PH_TAG_END, PH_CLOSE, PH_CLOSE_NAME, PH_CLOSE_END,
        PH_QMARK, PH_EXCL, PH_EXCL_DASH, PH_EXCL_DOCTYPE, PH_EXCL_CDATA, PH_DOCTYPE,
        PH_DOCTYPE_TEXT, PH_DOCTYPE_ATTR, PH_PI, PH_COMMENT, PH_CDATA
    } phase_t;

    typedef enum logic [2:0] {
        EL_TAG, EL_SELF, EL_XML, EL_CDATA, EL_DOCTYPE
    } elem_t;

    typedef enum logic [3:0] {
        EV_TEXT, EV_OPEN, EV_ATTR, EV_CLOSE, EV_PI, EV_COMMENT, EV_CDATA,
        EV_DTFIELD, EV_DTEND, EV_DONE, EV_ERROR
    } event_t;

    typedef struct packed {
        logic [15:0] char_code;
        logic        doc_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [31:0] first_start;
        logic [31:0] first_length;
        logic [31:0] second_start;
        logic [31:0] second_length;
        logic        all_space;
        logic [15:0] nest_depth;
        logic        last_of_run;
    } out_item_t;

    // Character classes on a 21-bit code (callers zero-extend)
    function automatic logic is_space(input logic [20:0] c);
        return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 ||
               c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202F || c == 21'h205F ||
               c == 21'h3000;
    endfunction

    function automatic logic is_letter(input logic [20:0] c);
        logic r;
        r = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
            c == 21'hAA || c == 21'hB5 || c == 21'hBA ||
            (c >= 21'hC0 && c <= 21'hFF && c != 21'hD7 && c != 21'hF7) ||
            (c >= 21'h100 && !is_space(c));
        return r;
    endfunction

    function automatic logic is_digit(input logic [20:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic name_extra(input logic [20:0] c);
        return c == 21'h5F || c == 21'h3A || c == 21'h2D || c == 21'h2E;
    endfunction

    // Keyword letters by match index
    function automatic logic [7:0] kw_doctype(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h44;
            3'd1: r = 8'h4F;
            3'd2: r = 8'h43;
            3'd3: r = 8'h54;
            3'd4: r = 8'h59;
            3'd5: r = 8'h50;
            3'd6: r = 8'h45;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_cdata(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h5B;
            3'd1: r = 8'h43;
            3'd2: r = 8'h44;
            3'd3: r = 8'h41;
            3'd4: r = 8'h54;
            3'd5: r = 8'h41;
            3'd6: r = 8'h5B;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_xml(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h78;
            2'd1: r = 8'h6D;
            2'd2: r = 8'h6C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/xst_front.sv
// Front end: character-class parse state machine producing up to three events per character.
`default_nettype none
module xst_front #(
    parameter int POS_WIDTH   = xst_pkg::POS_WIDTH_DEF,
    parameter int DEPTH_WIDTH = xst_pkg::DEPTH_WIDTH_DEF,
    parameter int CHAR_WIDTH  = xst_pkg::CHAR_WIDTH_DEF,
    parameter int MAX_DT_FIELDS = xst_pkg::MAX_DT_FIELDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire xst_pkg::in_item_t    item,
    output xst_pkg::out_item_t        ev [xst_pkg::MAX_EVENTS],
    output logic [1:0]                ev_count
);
    import xst_pkg::*;

    localparam logic [DEPTH_WIDTH-1:0] DMAX = {DEPTH_WIDTH{1'b1}};

    phase_t                 phase_reg, phase_next;
    elem_t                  elem_reg, elem_next;
    logic [CHAR_WIDTH-1:0]  quote_reg, quote_next;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [POS_WIDTH-1:0]   tmark_reg, tmark_next;
    logic [POS_WIDTH-1:0]   tns_reg, tns_next, tne_reg, tne_next;
    logic [POS_WIDTH-1:0]   ans_reg, ans_next, ane_reg, ane_next;
    logic [POS_WIDTH-1:0]   ds_reg, ds_next;
    logic [DEPTH_WIDTH-1:0] depth_reg, depth_next;
    logic [2:0]             dtf_reg, dtf_next;
    logic                   tsp_reg, tsp_next;
    logic [3:0]             kw_reg, kw_next;
    logic [1:0]             tm_reg, tm_next;
    logic                   halt_reg, halt_next;

    logic [20:0]            c;
    logic                   sp, let_c, dig, nx;
    logic [POS_WIDTH-1:0]   pos1;
    logic [1:0]             n;
    out_item_t              evs [MAX_EVENTS];
    logic                   finish;

    assign c     = 21'(item.char_code[CHAR_WIDTH-1:0]);
    assign sp    = is_space(c);
    assign let_c = is_letter(c);
    assign dig   = is_digit(c);
    assign nx    = name_extra(c);
    assign pos1  = pos_reg + POS_WIDTH'(1);

    // Register the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_READY;
            elem_reg  <= EL_TAG;
            quote_reg <= '0;
            pos_reg   <= '0;
            tmark_reg <= '0;
            tns_reg   <= '0;
            tne_reg   <= '0;
            ans_reg   <= '0;
            ane_reg   <= '0;
            ds_reg    <= '0;
            depth_reg <= '0;
            dtf_reg   <= '0;
            tsp_reg   <= 1'b1;
            kw_reg    <= '0;
            tm_reg    <= '0;
            halt_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            elem_reg  <= elem_next;
            quote_reg <= quote_next;
            pos_reg   <= pos_next;
            tmark_reg <= tmark_next;
            tns_reg   <= tns_next;
            tne_reg   <= tne_next;
            ans_reg   <= ans_next;
            ane_reg   <= ane_next;
            ds_reg    <= ds_next;
            depth_reg <= depth_next;
            dtf_reg   <= dtf_next;
            tsp_reg   <= tsp_next;
            kw_reg    <= kw_next;
            tm_reg    <= tm_next;
            halt_reg  <= halt_next;
        end
    end

    // Next state and events
    always_comb
    begin
        phase_next = phase_reg;
        elem_next  = elem_reg;
        quote_next = quote_reg;
        pos_next   = pos1;
        tmark_next = tmark_reg;
        tns_next   = tns_reg;
        tne_next   = tne_reg;
        ans_next   = ans_reg;
        ane_next   = ane_reg;
        ds_next    = ds_reg;
        depth_next = depth_reg;
        dtf_next   = dtf_reg;
        tsp_next   = tsp_reg;
        kw_next    = kw_reg;
        tm_next    = tm_reg;
        halt_next  = halt_reg;
        n          = 2'd0;
        finish     = 1'b0;
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            evs[i] = '0;
        end

        if (!halt_reg)
        begin
            unique case (phase_reg)
                PH_READY:
                begin
                    if (c == 21'h3C)
                    begin
                        if (tmark_reg != pos_reg)
                        begin
                            evs[n].event_kind   = EV_TEXT;
                            evs[n].first_start  = 32'(tmark_reg);
                            evs[n].first_length = 32'(pos_reg - tmark_reg);
                            evs[n].all_space    = tsp_reg;
                            evs[n].nest_depth   = 16'(depth_next);
                            n = n + 2'd1;
                        end
                        phase_next = PH_TAG_BEGIN;
                    end
                    else if (!sp)
                    begin
                        tsp_next = 1'b0;
                    end
                end
                PH_TAG_BEGIN:
                begin
                    if (let_c || c == 21'h5F || c == 21'h3A)
                    begin
                        phase_next = PH_TAG_NAME;
                        tns_next   = pos_reg;
                    end
                    else if (c == 21'h2F) phase_next = PH_CLOSE;
                    else if (c == 21'h3F)
                    begin
                        phase_next = PH_QMARK;
                        kw_next    = '0;
                        ds_next    = pos1;
                    end
                    else if (c == 21'h21) phase_next = PH_EXCL;
                    else if (!sp) halt_next = 1'b1;
                end
                PH_TAG_NAME, PH_TAG_INSIDE:
                begin
                    if (phase_reg == PH_TAG_NAME && (let_c || nx))
                    begin
                        phase_next = PH_TAG_NAME;
                    end
                    else if (phase_reg == PH_TAG_NAME && depth_reg == DMAX)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == PH_TAG_NAME)
                        begin
                            tne_next   = pos_reg;
                            depth_next = depth_reg + DEPTH_WIDTH'(1);
                            elem_next  = EL_TAG;
                            phase_next = PH_TAG_INSIDE;
                            evs[n].event_kind   = EV_OPEN;
                            evs[n].first_start  = 32'(tns_reg);
                            evs[n].first_length = 32'(pos_reg - tns_reg);
                            evs[n].nest_depth   = 16'(depth_next);
                            n = n + 2'd1;
                        end
                        // tag body character
                        if (sp)
                        begin
                        end
                        else if (let_c || c == 21'h5F)
                        begin
                            ans_next   = pos_reg;
                            phase_next = PH_ATTR_NAME;
                        end
                        else if (elem_next == EL_TAG && c == 21'h2F)
                        begin
                            elem_next  = EL_SELF;
                            phase_next = PH_TAG_END;
                        end
                        else if (elem_next == EL_TAG && c == 21'h3E)
                        begin
                            finish = 1'b1;
                        end
                        else if (elem_next == EL_XML && c == 21'h3F)
                        begin
                            phase_next = PH_TAG_END;
                        end
                        else halt_next = 1'b1;
                    end
                end
                PH_ATTR_NAME:
                begin
                    if (!(let_c || dig || nx))
                    begin
                        ane_next = pos_reg;
                        if (c == 21'h3D) phase_next = PH_ATTR_QUOTE;
                        else if (sp) phase_next = PH_ATTR_EQ;
                        else halt_next = 1'b1;
                    end
                end
                PH_ATTR_EQ:
                begin
                    if (c == 21'h3D) phase_next = PH_ATTR_QUOTE;
                    else if (!sp) halt_next = 1'b1;
                end
                PH_ATTR_QUOTE:
                begin
                    if (c == 21'h27 || c == 21'h22)
                    begin
                        quote_next = CHAR_WIDTH'(c);
                        ds_next    = pos1;
                        phase_next = PH_ATTR_VALUE;
                    end
                    else if (!sp) halt_next = 1'b1;
                end
                PH_ATTR_VALUE:
                begin
                    if (c == 21'(quote_reg))
                    begin
                        evs[n].event_kind    = EV_ATTR;
                        evs[n].first_start   = 32'(ans_reg);
                        evs[n].first_length  = 32'(ane_reg - ans_reg);
                        evs[n].second_start  = 32'(ds_reg);
                        evs[n].second_length = 32'(pos_reg - ds_reg);
                        evs[n].nest_depth    = 16'(depth_reg);
                        n = n + 2'd1;
                        phase_next = PH_TAG_INSIDE;
                    end
                end
                PH_TAG_END:
                begin
                    if (c == 21'h3E)
                    begin
                        if (elem_reg == EL_SELF)
                        begin
                            depth_next = depth_reg - DEPTH_WIDTH'(1);
                            evs[n].event_kind   = EV_CLOSE;
                            evs[n].first_start  = 32'(tns_reg);
                            evs[n].first_length = 32'(tne_reg - tns_reg);
                            evs[n].nest_depth   = 16'(depth_next);
                            n = n + 2'd1;
                        end
                        finish = 1'b1;
                    end
                end
                PH_CLOSE:
                begin
                    if (let_c || c == 21'h5F || c == 21'h3A)
                    begin
                        phase_next = PH_CLOSE_NAME;
                        tns_next   = pos_reg;
                    end
                    else halt_next = 1'b1;
                end
                PH_CLOSE_NAME, PH_CLOSE_END:
                begin
                    if (phase_reg == PH_CLOSE_NAME && (let_c || dig || nx))
                    begin
                        phase_next = PH_CLOSE_NAME;
                    end
                    else
                    begin
                        if (phase_reg == PH_CLOSE_NAME)
                        begin
                            tne_next   = pos_reg;
                            phase_next = PH_CLOSE_END;
                        end
                        if (c == 21'h3E)
                        begin
                            if (depth_reg == '0) halt_next = 1'b1;
                            else
                            begin
                                depth_next = depth_reg - DEPTH_WIDTH'(1);
                                evs[n].event_kind   = EV_CLOSE;
                                evs[n].first_start  = 32'(tns_reg);
                                evs[n].first_length = 32'(tne_next - tns_reg);
                                evs[n].nest_depth   = 16'(depth_next);
                                n = n + 2'd1;
                                finish = 1'b1;
                            end
                        end
                        else if (!sp) halt_next = 1'b1;
                    end
                end
                PH_QMARK:
                begin
                    if (kw_reg < 4'd3 && (c == 21'(kw_xml(kw_reg[1:0])) ||
                        c == 21'(kw_xml(kw_reg[1:0])) - 21'h20))
                    begin
                        kw_next = kw_reg + 4'd1;
                    end
                    else if (kw_reg >= 4'd3 && sp)
                    begin
                        elem_next  = EL_XML;
                        phase_next = PH_TAG_INSIDE;
                    end
                    else
                    begin
                        phase_next = PH_PI;
                        tm_next    = '0;
                        if (kw_reg != '0)
                        begin
                            tm_next = (c == 21'h3F) ? 2'd1 : 2'd0;
                        end
                    end
                end
                PH_EXCL:
                begin
                    kw_next = 4'd1;
                    if (c == 21'h2D) phase_next = PH_EXCL_DASH;
                    else if (c == 21'h44) phase_next = PH_EXCL_DOCTYPE;
                    else if (c == 21'h5B) phase_next = PH_EXCL_CDATA;
                    else halt_next = 1'b1;
                end
                PH_EXCL_DASH:
                begin
                    if (c == 21'h2D)
                    begin
                        phase_next = PH_COMMENT;
                        tm_next    = '0;
                        ds_next    = pos1;
                    end
                    else halt_next = 1'b1;
                end
                PH_EXCL_DOCTYPE:
                begin
                    if (kw_reg < 4'd7)
                    begin
                        if (c == 21'(kw_doctype(kw_reg[2:0]))) kw_next = kw_reg + 4'd1;
                        else halt_next = 1'b1;
                    end
                    else if (sp)
                    begin
                        elem_next  = EL_DOCTYPE;
                        dtf_next   = '0;
                        phase_next = PH_DOCTYPE;
                    end
                    else halt_next = 1'b1;
                end
                PH_EXCL_CDATA:
                begin
                    if (kw_reg < 4'd7 && c == 21'(kw_cdata(kw_reg[2:0])))
                    begin
                        kw_next = kw_reg + 4'd1;
                        if (kw_reg == 4'd6)
                        begin
                            elem_next  = EL_CDATA;
                            phase_next = PH_CDATA;
                            tm_next    = '0;
                            ds_next    = pos1;
                        end
                    end
                    else halt_next = 1'b1;
                end
                PH_DOCTYPE, PH_DOCTYPE_TEXT:
                begin
                    if (phase_reg == PH_DOCTYPE_TEXT && (let_c || dig || nx))
                    begin
                        phase_next = PH_DOCTYPE_TEXT;
                    end
                    else
                    begin
                        if (phase_reg == PH_DOCTYPE_TEXT)
                        begin
                            evs[n].event_kind   = EV_DTFIELD;
                            evs[n].first_start  = 32'(ds_reg);
                            evs[n].first_length = 32'(pos_reg - ds_reg);
                            evs[n].nest_depth   = 16'(depth_reg);
                            n = n + 2'd1;
                            dtf_next   = dtf_reg + 3'd1;
                            phase_next = PH_DOCTYPE;
                        end
                        if (sp)
                        begin
                        end
                        else if (c == 21'h3E)
                        begin
                            evs[n].event_kind = EV_DTEND;
                            evs[n].nest_depth = 16'(depth_reg);
                            n = n + 2'd1;
                            finish = 1'b1;
                        end
                        else if (dtf_next < 3'd2 && (let_c || c == 21'h5F))
                        begin
                            phase_next = PH_DOCTYPE_TEXT;
                            ds_next    = pos_reg;
                        end
                        else if (dtf_next >= 3'd2 && c == 21'h22 &&
                                 dtf_next < 3'(MAX_DT_FIELDS))
                        begin
                            phase_next = PH_DOCTYPE_ATTR;
                            ds_next    = pos1;
                        end
                        else halt_next = 1'b1;
                    end
                end
                PH_DOCTYPE_ATTR:
                begin
                    if (c == 21'h22)
                    begin
                        evs[n].event_kind   = EV_DTFIELD;
                        evs[n].first_start  = 32'(ds_reg);
                        evs[n].first_length = 32'(pos_reg - ds_reg);
                        evs[n].nest_depth   = 16'(depth_reg);
                        n = n + 2'd1;
                        dtf_next   = dtf_reg + 3'd1;
                        phase_next = PH_DOCTYPE;
                    end
                end
                PH_PI:
                begin
                    if (tm_reg == 2'd1 && c == 21'h3E)
                    begin
                        evs[n].event_kind   = EV_PI;
                        evs[n].first_start  = 32'(ds_reg);
                        evs[n].first_length = 32'(pos_reg - POS_WIDTH'(1) - ds_reg);
                        evs[n].nest_depth   = 16'(depth_reg);
                        n = n + 2'd1;
                        finish = 1'b1;
                    end
                    else tm_next = (c == 21'h3F) ? 2'd1 : 2'd0;
                end
                PH_COMMENT, PH_CDATA:
                begin
                    if (tm_reg == 2'd2 && c == 21'h3E)
                    begin
                        evs[n].event_kind   = (phase_reg == PH_COMMENT) ? EV_COMMENT
                                                                        : EV_CDATA;
                        evs[n].first_start  = 32'(ds_reg);
                        evs[n].first_length = 32'(pos_reg - POS_WIDTH'(2) - ds_reg);
                        evs[n].nest_depth   = 16'(depth_reg);
                        n = n + 2'd1;
                        finish = 1'b1;
                    end
                    else if (c == ((phase_reg == PH_COMMENT) ? 21'h2D : 21'h5D))
                    begin
                        tm_next = (tm_reg < 2'd2) ? tm_reg + 2'd1 : 2'd2;
                    end
                    else tm_next = '0;
                end
                default: halt_next = 1'b1;
            endcase

            // Return to text after markup
            if (finish)
            begin
                phase_next = PH_READY;
                tmark_next = pos1;
                tsp_next   = 1'b1;
            end

            // Report a syntax error
            if (halt_next)
            begin
                evs[n].event_kind  = EV_ERROR;
                evs[n].first_start = 32'(pos_reg);
                evs[n].nest_depth  = 16'(depth_next);
                n = n + 2'd1;
            end
        end

        // Close the document and restart
        if (item.doc_end)
        begin
            if (!halt_reg)
            begin
                if (phase_next == PH_READY && depth_next == '0)
                begin
                    evs[n].event_kind   = EV_DONE;
                    evs[n].first_length = 32'(pos1);
                    evs[n].nest_depth   = 16'(depth_next);
                    n = n + 2'd1;
                end
                else if (!halt_next)
                begin
                    evs[n].event_kind  = EV_ERROR;
                    evs[n].first_start = 32'(pos_reg);
                    evs[n].nest_depth  = 16'(depth_next);
                    n = n + 2'd1;
                end
            end
            phase_next = PH_READY;
            elem_next  = EL_TAG;
            quote_next = '0;
            pos_next   = '0;
            tmark_next = '0;
            tns_next   = '0;
            tne_next   = '0;
            ans_next   = '0;
            ane_next   = '0;
            ds_next    = '0;
            depth_next = '0;
            dtf_next   = '0;
            tsp_next   = 1'b1;
            kw_next    = '0;
            tm_next    = '0;
            halt_next  = 1'b0;
        end

        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            evs[i].last_of_run = (2'(i + 1) == n);
        end
        ev       = evs;
        ev_count = n;
    end

endmodule
`default_nettype wire

// File: hw/rtl/xst_queue.sv
// Event queue between the parser and the result port; takes up to three events per transfer.
`default_nettype none
module xst_queue #(
    parameter int DEPTH = xst_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire xst_pkg::out_item_t   wdata [xst_pkg::MAX_EVENTS],
    input  wire logic [1:0]           wcount,
    output logic                      room,
    output logic                      empty,
    input  wire logic                 pop,
    output xst_pkg::out_item_t        rdata
);
    import xst_pkg::*;

    localparam int AW = $clog2(DEPTH);

    out_item_t          mem_reg [DEPTH];
    logic [AW-1:0]      wp_reg, rp_reg;
    logic [AW:0]        cnt_reg, cnt_next;
    logic               do_pop;
    logic [1:0]         nin;

    assign do_pop = pop && !empty;
    assign nin    = push ? wcount : 2'd0;
    assign empty  = (cnt_reg == '0);
    assign room   = (32'(cnt_reg) + MAX_EVENTS <= DEPTH);
    assign rdata  = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + (AW+1)'(nin) - (AW+1)'(do_pop);

    // Advance the pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + AW'(nin);
            rp_reg  <= rp_reg + AW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

    // Write the new events
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (2'(i) < nin)
            begin
                mem_reg[wp_reg + AW'(i)] <= wdata[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/xml_sax_tokenizer.sv
// Top level of the XML SAX tokenizer: parser front end and event queue.
//
//  channel | direction | handshake            | payload
//  input   | in        | push / full          | in_item_t  (char_code, doc_end)
//  result  | out       | empty / pop          | out_item_t (one SAX event)
//
// One character is taken per cycle while the event queue has room for three events.
// The parser state updates in the cycle of the transfer, when its events are queued;
// they reach the result port behind earlier ones and leave one per pop. A character
// giving several events holds input while the queue drains. Reset is asynchronous.
`default_nettype none
module xml_sax_tokenizer #(
    parameter int POS_WIDTH     = xst_pkg::POS_WIDTH_DEF,
    parameter int DEPTH_WIDTH   = xst_pkg::DEPTH_WIDTH_DEF,
    parameter int CHAR_WIDTH    = xst_pkg::CHAR_WIDTH_DEF,
    parameter int MAX_DT_FIELDS = xst_pkg::MAX_DT_FIELDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire xst_pkg::in_item_t    in_item,
    output logic                      empty,
    input  wire logic                 pop,
    output xst_pkg::out_item_t        out_item
);
    import xst_pkg::*;

    out_item_t  ev [MAX_EVENTS];
    logic [1:0] ev_count;
    logic       room, step;

    assign full = !room;
    assign step = push && room;

    xst_front #(
        .POS_WIDTH(POS_WIDTH), .DEPTH_WIDTH(DEPTH_WIDTH),
        .CHAR_WIDTH(CHAR_WIDTH), .MAX_DT_FIELDS(MAX_DT_FIELDS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_item),
        .ev(ev), .ev_count(ev_count)
    );

    xst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(step), .wdata(ev), .wcount(ev_count),
        .room(room), .empty(empty), .pop(pop), .rdata(out_item)
    );

endmodule
`default_nettype wire

// File: hw/rtl/xst_checker.sv
// Port checker for the XML tokenizer, bound to the top level.
`default_nettype none
module xst_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire xst_pkg::out_item_t out_item
);
    import xst_pkg::*;

    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while waiting");

    // Event kinds stay in range
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.event_kind <= EV_ERROR))
        else $error("bad event kind");

    // Only attribute events carry a second span
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.event_kind != EV_ATTR) |->
        (out_item.second_start == '0 && out_item.second_length == '0))
        else $error("second span on non-attribute event");

    // Queue with nothing in it has room
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !full)
        else $error("full while empty");

endmodule

bind xml_sax_tokenizer xst_checker u_xst_checker (
    .clk(clk), .rst_n(rst_n), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item)
);
`default_nettype wire
